// ===== rtl/sfr_pkg.sv =====
// shared constants and types for the serial frame receiver
package sfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned COUNT_W         = 7;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] END_BYTE   = 8'h0D;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_ID,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_END,
    PH_READ,
    PH_LOAD,
    PH_EMPTY
  } phase_t;

endpackage

// ===== rtl/serial_frame_receiver.sv =====
// serial frame receiver: hunts 0x7E framed messages and replays good payloads
//
//   channel | beat                                          | handshake
//   --------+-----------------------------------------------+--------------------
//   rx      | rx_byte                                       | rx_valid / rx_stall
//   res     | msg_id, payload_byte, payload_valid,          | res_valid / res_stall
//           | payload_count, last                           |
//
// - rx_stall stays low while the receiver is hunting or
//   collecting a frame; payload bytes go straight into the payload memory
// - a good end byte starts the replay: each payload beat is a memory read, then an
//   output register load, and rx is held off until the last beat is loaded; an
//   empty frame gives a single beat
// - rx_stall is high for the whole replay, and a beat held by res_stall holds the
//   replay where it is
// - the output register lets the last beat of a frame wait while rx goes on
// - rst is synchronous; it sends the receiver back to hunting and empties the
//   output register; the payload memory is not cleared (only bytes of the current
//   frame are ever read back)
module serial_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rx_valid,
  output logic                         rx_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [7:0]                   msg_id,
  output logic [7:0]                   payload_byte,
  output logic                         payload_valid,
  output logic [sfr_pkg::COUNT_W-1:0]  payload_count,
  output logic                         last
);

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = sfr_pkg::COUNT_W;

  sfr_pkg::phase_t phase, phase_next;

  logic [7:0]    frame_id;
  logic [CW-1:0] bytes_remaining;   // payload bytes still to come
  logic [CW-1:0] write_position;    // next payload slot, also the byte count
  logic [7:0]    running_sum;
  logic [CW-1:0] frame_count;       // bytes to replay
  logic [CW-1:0] read_position;     // slot being replayed

  logic       rx_take;
  logic       res_free;
  logic       rd_en;
  logic       load_beat;
  logic [7:0] rd_data;
  logic [7:0] len_m1;
  logic       len_short;
  logic       len_too_long;
  logic       replay_last;

  // beat handshakes
  assign rx_take  = rx_valid && !rx_stall;
  assign res_free = !res_valid || !res_stall;

  // length byte decode: the length counts itself
  assign len_m1       = rx_byte - 8'd1;
  assign len_short    = (rx_byte <= 8'd1);
  assign len_too_long = (len_m1 > 8'(MAX_PAYLOAD));

  assign replay_last = ((read_position + CW'(1)) == frame_count);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      sfr_pkg::PH_HUNT: begin
        if (rx_take && rx_byte == sfr_pkg::START_BYTE) begin
          phase_next = sfr_pkg::PH_ID;
        end
      end
      sfr_pkg::PH_ID: begin
        if (rx_take) begin
          phase_next = sfr_pkg::PH_LEN;
        end
      end
      sfr_pkg::PH_LEN: begin
        if (rx_take) begin
          if (len_short) begin
            phase_next = sfr_pkg::PH_SUM;
          end else if (len_too_long) begin
            phase_next = sfr_pkg::PH_HUNT;
          end else begin
            phase_next = sfr_pkg::PH_DATA;
          end
        end
      end
      sfr_pkg::PH_DATA: begin
        if (rx_take && bytes_remaining == CW'(1)) begin
          phase_next = sfr_pkg::PH_SUM;
        end
      end
      sfr_pkg::PH_SUM: begin
        if (rx_take) begin
          phase_next = (rx_byte == running_sum) ? sfr_pkg::PH_END : sfr_pkg::PH_HUNT;
        end
      end
      sfr_pkg::PH_END: begin
        if (rx_take) begin
          if (rx_byte != sfr_pkg::END_BYTE) begin
            phase_next = sfr_pkg::PH_HUNT;
          end else if (write_position == '0) begin
            phase_next = sfr_pkg::PH_EMPTY;
          end else begin
            phase_next = sfr_pkg::PH_READ;
          end
        end
      end
      sfr_pkg::PH_READ: begin
        phase_next = sfr_pkg::PH_LOAD;
      end
      sfr_pkg::PH_LOAD: begin
        if (res_free) begin
          phase_next = replay_last ? sfr_pkg::PH_HUNT : sfr_pkg::PH_READ;
        end
      end
      sfr_pkg::PH_EMPTY: begin
        if (res_free) begin
          phase_next = sfr_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_next = sfr_pkg::PH_HUNT;
      end
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    rx_stall  = 1'b0;
    rd_en     = 1'b0;
    load_beat = 1'b0;
    unique case (phase) inside
      sfr_pkg::PH_READ: begin
        rx_stall = 1'b1;
        rd_en    = 1'b1;
      end
      sfr_pkg::PH_LOAD, sfr_pkg::PH_EMPTY: begin
        rx_stall  = 1'b1;
        load_beat = res_free;
      end
      default: begin
        rx_stall = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sfr_pkg::PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  // frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id        <= '0;
      bytes_remaining <= '0;
      write_position  <= '0;
      running_sum     <= '0;
      frame_count     <= '0;
      read_position   <= '0;
    end else begin
      if (rx_take) begin
        unique case (phase)
          sfr_pkg::PH_HUNT: begin
            if (rx_byte == sfr_pkg::START_BYTE) begin
              write_position <= '0;
              running_sum    <= '0;
            end
          end
          sfr_pkg::PH_ID: begin
            frame_id <= rx_byte;
          end
          sfr_pkg::PH_LEN: begin
            running_sum    <= rx_byte;
            write_position <= '0;
            if (len_short || len_too_long) begin
              bytes_remaining <= '0;
            end else begin
              bytes_remaining <= len_m1[CW-1:0];
            end
          end
          sfr_pkg::PH_DATA: begin
            write_position  <= write_position + CW'(1);
            running_sum     <= running_sum + rx_byte;
            bytes_remaining <= bytes_remaining - CW'(1);
          end
          sfr_pkg::PH_END: begin
            frame_count   <= write_position;
            read_position <= '0;
          end
          default: begin
            frame_count <= frame_count;
          end
        endcase
      end
      if (load_beat && phase == sfr_pkg::PH_LOAD) begin
        read_position <= read_position + CW'(1);
      end
    end
  end

  sfr_payload_ram #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (rx_take && phase == sfr_pkg::PH_DATA),
    .wr_addr (write_position[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (read_position[AW-1:0]),
    .rd_data (rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_beat) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_beat) begin
      msg_id <= frame_id;
      if (phase == sfr_pkg::PH_EMPTY) begin
        payload_byte  <= '0;
        payload_valid <= 1'b0;
        payload_count <= '0;
        last          <= 1'b1;
      end else begin
        payload_byte  <= rd_data;
        payload_valid <= 1'b1;
        payload_count <= frame_count;
        last          <= replay_last;
      end
    end
  end

endmodule

// ===== rtl/sfr_payload_ram.sv =====
// payload store: one write port, one read port with registered read data
module sfr_payload_ram #(
  parameter int unsigned DEPTH = sfr_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sfr_checker.sv =====
// port-level checks for the serial frame receiver, bound to the top level
module sfr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rx_valid,
  input logic                        rx_stall,
  input logic [7:0]                  rx_byte,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic [7:0]                  msg_id,
  input logic [7:0]                  payload_byte,
  input logic                        payload_valid,
  input logic [sfr_pkg::COUNT_W-1:0] payload_count,
  input logic                        last
);

  // a stalled beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(payload_byte) && $stable(msg_id)
      && $stable(last) && $stable(payload_count))
    else $error("stalled result beat changed");

  // rx stays held off while a frame replay is unfinished
  a_replay_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> rx_stall)
    else $error("rx open in the middle of a replay");

  // an empty frame is one beat of zeros marked last
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !payload_valid |-> last && payload_count == '0 && payload_byte == '0)
    else $error("bad empty-frame beat");

  // a non-last data beat is followed by another beat of the same frame
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !last |-> ##[1:2] (res_valid && $stable(msg_id)))
    else $error("replay run broken");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);
